// File: hw/rtl/tt_pkg.sv
// ----------------------------------------------------------------------------
// tt_pkg
// Types, constants and helpers shared by the triangle tangent block.
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int TT_QUEUE_DEPTH = 2;

    typedef logic signed [32:0] t_diff;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] tex_u;
        logic signed [31:0] tex_v;
    } t_in;

    typedef struct packed {
        logic signed [31:0] tangent_x;
        logic signed [31:0] tangent_y;
        logic signed [31:0] tangent_z;
        logic               degenerate;
    } t_out;

    typedef struct packed {
        t_diff du1;
        t_diff dv1;
        t_diff du2;
        t_diff dv2;
        t_diff dx1;
        t_diff dy1;
        t_diff dz1;
        t_diff dx2;
        t_diff dy2;
        t_diff dz2;
    } t_job;

    typedef enum logic [2:0] {
        B_IDLE,
        B_MUL0,
        B_MUL1,
        B_MUL2,
        B_DSET,
        B_DIV,
        B_DONE
    } t_bstate;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    function automatic t_diff diff33(logic signed [31:0] a, logic signed [31:0] b);
        return 33'(a) - 33'(b);
    endfunction

endpackage

// File: hw/rtl/tt_fifo.sv
// ----------------------------------------------------------------------------
// tt_fifo
// Short first-in first-out queue that decouples the vertex front end from
// the arithmetic back end.
// ----------------------------------------------------------------------------
module tt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wptr;
    logic [PW-1:0]    r_rptr;
    logic [CW-1:0]    r_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

endmodule

// File: hw/rtl/tt_front.sv
// ----------------------------------------------------------------------------
// tt_front
// Accepts vertex beats, holds the first two corners of each triangle and on
// the third corner queues the edge differences of the triangle.
// ----------------------------------------------------------------------------
module tt_front
    import tt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_push,
    output t_job o_job,
    input  logic i_full
);

    logic [1:0] r_count;
    t_in        r_c0;
    t_in        r_c1;
    logic       take;

    assign o_ready = (r_count != 2'd2) || !i_full;
    assign take    = i_valid && o_ready;
    assign o_push  = take && (r_count == 2'd2);

    always_comb begin
        o_job.du1 = diff33(r_c1.tex_u, r_c0.tex_u);
        o_job.dv1 = diff33(r_c1.tex_v, r_c0.tex_v);
        o_job.du2 = diff33(i_data.tex_u, r_c1.tex_u);
        o_job.dv2 = diff33(i_data.tex_v, r_c1.tex_v);
        o_job.dx1 = diff33(r_c1.pos_x, r_c0.pos_x);
        o_job.dy1 = diff33(r_c1.pos_y, r_c0.pos_y);
        o_job.dz1 = diff33(r_c1.pos_z, r_c0.pos_z);
        o_job.dx2 = diff33(i_data.pos_x, r_c1.pos_x);
        o_job.dy2 = diff33(i_data.pos_y, r_c1.pos_y);
        o_job.dz2 = diff33(i_data.pos_z, r_c1.pos_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else if (take) begin
            r_count <= (r_count == 2'd2) ? 2'd0 : r_count + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take && r_count == 2'd0) begin
            r_c0 <= i_data;
        end
        if (take && r_count == 2'd1) begin
            r_c1 <= i_data;
        end
    end

endmodule

// File: hw/rtl/tt_back.sv
// ----------------------------------------------------------------------------
// tt_back
// Forms the shared uv cross term and the three per-axis terms on one
// multiplier, divides with a two-bit-per-cycle restoring divider, saturates
// and presents the result in an output register.
// ----------------------------------------------------------------------------
module tt_back
    import tt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_job_empty,
    input  t_job i_job,
    output logic o_job_pop,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    t_bstate r_state;
    t_bstate n_state;

    t_job               r_job;
    logic               r_is_a;
    logic [1:0]         r_axis;
    logic signed [65:0] r_prod;
    logic signed [65:0] r_first;
    logic signed [66:0] r_b;
    logic [66:0]        r_den;
    logic               r_a_neg;
    logic               r_neg;
    logic [67:0]        r_rem;
    logic [31:0]        r_numlo;
    logic [31:0]        r_q;
    logic [3:0]         r_cnt;
    logic [31:0]        r_tan [3];
    logic               r_degen;
    logic               r_out_valid;
    t_out               r_out;

    t_diff              mul_a;
    t_diff              mul_b;
    logic signed [65:0] mul_p;
    logic signed [66:0] diff;
    logic [66:0]        diff_mag;
    logic [66:0]        b_mag;
    logic [82:0]        num;
    logic               ovf;
    logic [67:0]        div_rem;
    logic [31:0]        div_numlo;
    logic [31:0]        div_q;
    logic               out_free;
    logic               tan_we;
    logic [31:0]        tan_val;

    function automatic logic [31:0] sat_q(logic neg, logic over, logic [31:0] q);
        logic [31:0] res;
        if (neg) begin
            res = (over || q > 32'h8000_0000) ? 32'h8000_0000 : 32'(-q);
        end else begin
            res = (over || q > 32'h7FFF_FFFF) ? 32'h7FFF_FFFF : q;
        end
        return res;
    endfunction

    always_comb begin
        unique case (r_axis)
            AXIS_X: begin
                mul_a = (r_state == B_MUL0) ? r_job.dv1 : r_job.dx1;
                mul_b = (r_state == B_MUL0) ? r_job.dx2 : r_job.dv2;
            end
            AXIS_Y: begin
                mul_a = (r_state == B_MUL0) ? r_job.dv1 : r_job.dy1;
                mul_b = (r_state == B_MUL0) ? r_job.dy2 : r_job.dv2;
            end
            default: begin
                mul_a = (r_state == B_MUL0) ? r_job.dv1 : r_job.dz1;
                mul_b = (r_state == B_MUL0) ? r_job.dz2 : r_job.dv2;
            end
        endcase
        if (r_is_a) begin
            mul_a = (r_state == B_MUL0) ? r_job.du1 : r_job.dv1;
            mul_b = (r_state == B_MUL0) ? r_job.dv2 : r_job.du2;
        end
    end

    assign mul_p    = mul_a * mul_b;
    assign diff     = 67'(r_first) - 67'(r_prod);
    assign diff_mag = diff[66] ? 67'(-diff) : 67'(diff);
    assign b_mag    = r_b[66] ? 67'(-r_b) : 67'(r_b);
    assign num      = {b_mag[66:0], 16'd0};
    assign ovf      = {16'd0, num} >= {r_den, 32'd0};

    always_comb begin
        div_rem   = r_rem;
        div_numlo = r_numlo;
        div_q     = r_q;
        for (int j = 0; j < 2; j++) begin
            div_rem   = {div_rem[66:0], div_numlo[31]};
            div_numlo = {div_numlo[30:0], 1'b0};
            if (div_rem >= {1'b0, r_den}) begin
                div_rem = div_rem - {1'b0, r_den};
                div_q   = {div_q[30:0], 1'b1};
            end else begin
                div_q   = {div_q[30:0], 1'b0};
            end
        end
    end

    assign out_free  = !r_out_valid || i_ready;
    assign o_valid   = r_out_valid;
    assign o_data    = r_out;

    always_comb begin
        n_state   = r_state;
        o_job_pop = 1'b0;
        tan_we    = 1'b0;
        tan_val   = sat_q(r_neg, 1'b0, div_q);
        unique case (r_state)
            B_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_state   = B_MUL0;
                end
            end
            B_MUL0: begin
                n_state = B_MUL1;
            end
            B_MUL1: begin
                n_state = B_MUL2;
            end
            B_MUL2: begin
                if (r_is_a) begin
                    n_state = (diff == '0) ? B_DONE : B_MUL0;
                end else begin
                    n_state = B_DSET;
                end
            end
            B_DSET: begin
                if (ovf) begin
                    tan_we  = 1'b1;
                    tan_val = sat_q(r_neg, 1'b1, 32'd0);
                    n_state = (r_axis == AXIS_Z) ? B_DONE : B_MUL0;
                end else begin
                    n_state = B_DIV;
                end
            end
            B_DIV: begin
                if (r_cnt == 4'd15) begin
                    tan_we  = 1'b1;
                    n_state = (r_axis == AXIS_Z) ? B_DONE : B_MUL0;
                end
            end
            B_DONE: begin
                if (out_free) begin
                    n_state = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == B_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_job  <= i_job;
            r_is_a <= 1'b1;
            r_axis <= AXIS_X;
        end
        if (r_state == B_MUL0 || r_state == B_MUL1) begin
            r_prod <= mul_p;
        end
        if (r_state == B_MUL1) begin
            r_first <= r_prod;
        end
        if (r_state == B_MUL2) begin
            if (r_is_a) begin
                r_den   <= diff_mag;
                r_a_neg <= diff[66];
                r_is_a  <= 1'b0;
                r_degen <= (diff == '0);
                if (diff == '0) begin
                    r_tan[0] <= 32'd0;
                    r_tan[1] <= 32'd0;
                    r_tan[2] <= 32'd0;
                end
            end else begin
                r_b   <= diff;
                r_neg <= (diff != '0) && (diff[66] == r_a_neg);
            end
        end
        if (r_state == B_DSET) begin
            r_rem   <= 68'(num[82:32]);
            r_numlo <= num[31:0];
            r_q     <= 32'd0;
            r_cnt   <= 4'd0;
        end
        if (r_state == B_DIV) begin
            r_rem   <= div_rem;
            r_numlo <= div_numlo;
            r_q     <= div_q;
            r_cnt   <= r_cnt + 4'd1;
        end
        if (tan_we) begin
            r_tan[r_axis] <= tan_val;
            r_axis        <= r_axis + 2'd1;
        end
        if (r_state == B_DONE && out_free) begin
            r_out.tangent_x  <= r_tan[0];
            r_out.tangent_y  <= r_tan[1];
            r_out.tangent_z  <= r_tan[2];
            r_out.degenerate <= r_degen;
        end
    end

`ifndef SYNTHESIS
    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.degenerate) |->
            (o_data.tangent_x == 32'd0 && o_data.tangent_y == 32'd0
             && o_data.tangent_z == 32'd0))
        else $error("degenerate result carries a nonzero tangent");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DSET || r_state == B_DIV) |-> (r_den != '0))
        else $error("division started with a zero divisor");

    a_rem_below: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DIV) |-> (r_rem < {1'b0, r_den}))
        else $error("divider remainder not below divisor");

    a_axis_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == B_DSET || r_state == B_DIV) |-> (r_axis != 2'd3))
        else $error("axis index out of range during division");
`endif

endmodule

// File: hw/rtl/triangle_tangent_from_uv.sv
// ----------------------------------------------------------------------------
// triangle_tangent_from_uv
// Per-triangle tangent vector from texture coordinates in signed Q16.16.
// ----------------------------------------------------------------------------
// Vertices arrive one per input beat and every three form a triangle; the
// third beat of each triangle yields one output beat with the saturated
// tangent and a degenerate flag. The front end takes a vertex every cycle
// while its queue has room, so short bursts of triangles are absorbed. The
// back end shares one 33x33 multiplier and a two-bit-per-cycle divider
// and takes one triangle at a time: an axis whose quotient needs more than
// 32 bits skips the division and saturates, and a zero uv cross term skips
// all three axes and flags the triangle degenerate.
module triangle_tangent_from_uv
    import tt_pkg::*;
#(
    parameter int QUEUE_DEPTH = TT_QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_ready,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_ready,
    output t_out o_data
);

    logic push;
    logic full;
    logic pop;
    logic empty;
    t_job job_in;
    t_job job_out;

    tt_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_push  (push),
        .o_job   (job_in),
        .i_full  (full)
    );

    tt_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (job_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (job_out),
        .o_empty (empty)
    );

    tt_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (empty),
        .i_job       (job_out),
        .o_job_pop   (pop),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule

// File: dv/tangent_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tangent_checker
// Watches both channels of the triangle tangent block, predicts the tangent
// of every third vertex beat and compares each output beat with the oldest
// prediction, field by field.
// ----------------------------------------------------------------------------
module tangent_checker
    import tt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_ready,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_ready,
    input  t_out i_out_data,
    output int   o_fail_count,
    output int   o_pending
);

    localparam logic signed [99:0] TANGENT_MAX = 100'sh7fff_ffff;
    localparam logic signed [99:0] TANGENT_MIN = -100'sh8000_0000;

    t_in  held_corner [2];
    int   corners_held = 0;
    t_out tangent_expect_q [$];
    int   fail_count = 0;
    int   pending = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic logic signed [31:0] axis_of(t_in vtx, logic [1:0] axis);
        case (axis)
            AXIS_X:  return vtx.pos_x;
            AXIS_Y:  return vtx.pos_y;
            default: return vtx.pos_z;
        endcase
    endfunction

    function automatic t_out triangle_tangent(t_in c0, t_in c1, t_in c2);
        logic signed [33:0] du1, dv1, du2, dv2, dp1, dp2;
        logic signed [69:0] area, bterm;
        logic signed [99:0] num, den, quo;
        logic signed [31:0] comp [3];
        t_out               tangent;
        tangent = '0;
        du1 = $signed(c1.tex_u) - $signed(c0.tex_u);
        dv1 = $signed(c1.tex_v) - $signed(c0.tex_v);
        du2 = $signed(c2.tex_u) - $signed(c1.tex_u);
        dv2 = $signed(c2.tex_v) - $signed(c1.tex_v);
        area = du1 * dv2 - dv1 * du2;
        if (area == 0) begin
            tangent.degenerate = 1'b1;
            return tangent;
        end
        den = area;
        for (int k = 0; k < 3; k++) begin
            dp1 = axis_of(c1, 2'(k)) - axis_of(c0, 2'(k));
            dp2 = axis_of(c2, 2'(k)) - axis_of(c1, 2'(k));
            bterm = dv1 * dp2 - dp1 * dv2;
            num = bterm;
            num = (-num) <<< 16;
            quo = num / den;
            if (quo > TANGENT_MAX) begin
                comp[k] = 32'h7fff_ffff;
            end else if (quo < TANGENT_MIN) begin
                comp[k] = 32'h8000_0000;
            end else begin
                comp[k] = quo[31:0];
            end
        end
        tangent.tangent_x = comp[0];
        tangent.tangent_y = comp[1];
        tangent.tangent_z = comp[2];
        return tangent;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n) begin
            if (i_in_valid && i_in_ready) begin
                if (corners_held < 2) begin
                    held_corner[corners_held] = i_in_data;
                    corners_held++;
                end else begin
                    tangent_expect_q = {tangent_expect_q,
                        triangle_tangent(held_corner[0], held_corner[1], i_in_data)};
                    corners_held = 0;
                end
            end
            if (i_out_valid && i_out_ready) begin
                if (tangent_expect_q.size() == 0) begin
                    if (fail_count < 10) begin
                        $display("%0t: unexpected output beat x=%h y=%h z=%h degenerate=%b",
                                 $realtime, i_out_data.tangent_x, i_out_data.tangent_y,
                                 i_out_data.tangent_z, i_out_data.degenerate);
                    end
                    fail_count++;
                end else begin
                    want = tangent_expect_q.pop_front();
                    if (want.tangent_x !== i_out_data.tangent_x ||
                        want.tangent_y !== i_out_data.tangent_y ||
                        want.tangent_z !== i_out_data.tangent_z ||
                        want.degenerate !== i_out_data.degenerate) begin
                        if (fail_count < 10) begin
                            $display("%0t: mismatch, expected x=%h y=%h z=%h degenerate=%b",
                                     $realtime, want.tangent_x, want.tangent_y,
                                     want.tangent_z, want.degenerate);
                            $display("%0t:           actual   x=%h y=%h z=%h degenerate=%b",
                                     $realtime, i_out_data.tangent_x, i_out_data.tangent_y,
                                     i_out_data.tangent_z, i_out_data.degenerate);
                        end
                        fail_count++;
                    end
                end
            end
        end
        pending = tangent_expect_q.size();
    end

endmodule

// File: dv/tb_triangle_tangent_from_uv.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_triangle_tangent_from_uv
// Feeds the triangle tangent block a directed set of triangles followed by
// random ones of several shapes, under phases of sender idling and receiver
// stalls, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module tb_triangle_tangent_from_uv;
    import tt_pkg::*;

    localparam int CYCLE_LIMIT         = 300000;
    localparam int DRAIN_CYCLES        = 200;
    localparam int TRIANGLES_PER_PHASE = 42;

    localparam logic signed [31:0] ONE   = 32'sh0001_0000;
    localparam logic signed [31:0] Q_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

    logic i_clk     = 1'b0;
    logic i_rst_n   = 1'b0;
    logic in_valid  = 1'b0;
    t_in  in_data   = '0;
    logic in_ready;
    logic out_valid;
    logic out_ready = 1'b0;
    t_out out_data;

    int idle_pct    = 0;
    int stall_pct   = 0;
    int cycle_count = 0;
    int fail_count;
    int pending;

    t_in vertex_q [$];

    always #5 i_clk = ~i_clk;

    triangle_tangent_from_uv uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_data  (out_data)
    );

    tangent_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always @(posedge i_clk) begin
        out_ready <= ($urandom_range(99) >= stall_pct);
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_vertex(input logic signed [31:0] px, input logic signed [31:0] py,
                                input logic signed [31:0] pz, input logic signed [31:0] u,
                                input logic signed [31:0] v);
        t_in vtx;
        vtx.pos_x = px;
        vtx.pos_y = py;
        vtx.pos_z = pz;
        vtx.tex_u = u;
        vtx.tex_v = v;
        vertex_q = {vertex_q, vtx};
    endtask

    function automatic logic signed [31:0] extreme_value();
        case ($urandom_range(5))
            0:       return Q_MAX;
            1:       return Q_MIN;
            2:       return '0;
            3:       return -32'sd1;
            4:       return 32'sd1;
            default: return $urandom;
        endcase
    endfunction

    task automatic queue_random_triangle();
        t_in corner [3];
        int  shape;
        int  base_u, base_v, step_u, step_v, stride, k;
        shape  = $urandom_range(9);
        base_u = $signed($urandom_range(2097152)) - 1048576;
        base_v = $signed($urandom_range(2097152)) - 1048576;
        step_u = $signed($urandom_range(2048)) - 1024;
        step_v = $signed($urandom_range(2048)) - 1024;
        stride = $signed($urandom_range(6)) - 3;
        for (int c = 0; c < 3; c++) begin
            case (shape)
                0, 1: begin
                    corner[c] = {$urandom, $urandom, $urandom, $urandom, $urandom};
                end
                2, 3, 4: begin
                    corner[c].pos_x = $signed($urandom_range(13107200)) - 6553600;
                    corner[c].pos_y = $signed($urandom_range(13107200)) - 6553600;
                    corner[c].pos_z = $signed($urandom_range(13107200)) - 6553600;
                    corner[c].tex_u = $signed($urandom_range(65536));
                    corner[c].tex_v = $signed($urandom_range(65536));
                end
                5, 6: begin
                    corner[c].pos_x = $signed($urandom_range(16)) - 8;
                    corner[c].pos_y = $signed($urandom_range(16)) - 8;
                    corner[c].pos_z = $signed($urandom_range(16)) - 8;
                    corner[c].tex_u = $signed($urandom_range(16)) - 8;
                    corner[c].tex_v = $signed($urandom_range(16)) - 8;
                end
                7: begin
                    k = (c == 0) ? 0 : (c == 1) ? 1 : stride;
                    corner[c].pos_x = $urandom;
                    corner[c].pos_y = $urandom;
                    corner[c].pos_z = $urandom;
                    corner[c].tex_u = base_u + k * step_u;
                    corner[c].tex_v = base_v + k * step_v;
                end
                default: begin
                    corner[c].pos_x = extreme_value();
                    corner[c].pos_y = extreme_value();
                    corner[c].pos_z = extreme_value();
                    corner[c].tex_u = extreme_value();
                    corner[c].tex_v = extreme_value();
                end
            endcase
            vertex_q = {vertex_q, corner[c]};
        end
    endtask

    task automatic drive_queue();
        bit presenting;
        presenting = 1'b0;
        while (vertex_q.size() != 0 || presenting) begin
            @(posedge i_clk);
            if (!presenting || in_ready) begin
                if (vertex_q.size() != 0 && $urandom_range(99) >= idle_pct) begin
                    in_data    <= vertex_q.pop_front();
                    in_valid   <= 1'b1;
                    presenting = 1'b1;
                end else begin
                    in_valid   <= 1'b0;
                    presenting = 1'b0;
                end
            end
        end
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // A unit triangle with a tangent of exactly one along x.
        queue_vertex('0, '0, '0, '0, '0);
        queue_vertex(ONE, '0, '0, ONE, '0);
        queue_vertex(ONE, ONE, '0, ONE, ONE);
        // All three texture coordinates identical, so the divisor is zero.
        queue_vertex(32'sh0012_3400, -ONE, Q_MAX, 32'sh1234_5678, -32'sd5);
        queue_vertex(-32'sd7, Q_MIN, ONE, 32'sh1234_5678, -32'sd5);
        queue_vertex(ONE, 32'sd3, -ONE, 32'sh1234_5678, -32'sd5);
        // Collinear texture coordinates also give a zero divisor.
        queue_vertex('0, ONE, -ONE, '0, '0);
        queue_vertex(ONE, '0, 32'sd9, ONE, ONE);
        queue_vertex(-ONE, 32'sd4, '0, ONE + ONE, ONE + ONE);
        // A tiny divisor drives x to positive and y to negative saturation.
        queue_vertex('0, '0, '0, '0, '0);
        queue_vertex(Q_MAX, Q_MIN, 32'sd1, 32'sd1, '0);
        queue_vertex(Q_MAX, Q_MIN, 32'sd1, 32'sd1, 32'sd1);
        // Quotients of thirds check truncation toward zero on both signs.
        queue_vertex('0, '0, '0, '0, '0);
        queue_vertex(-32'sd1, 32'sd1, 32'sd2, 32'sd3, '0);
        queue_vertex(-32'sd1, 32'sd1, 32'sd2, 32'sd3, 32'sd1);
        // Texture coordinates at both ends of their range.
        queue_vertex(Q_MIN, Q_MAX, -32'sd1, Q_MIN, Q_MAX);
        queue_vertex(Q_MAX, Q_MIN, '0, Q_MAX, Q_MIN);
        queue_vertex(-32'sd1, '0, Q_MAX, Q_MIN, Q_MIN);
        // Equal positions give a zero tangent with a valid divisor.
        queue_vertex(-32'sd1, -32'sd1, -32'sd1, '0, '0);
        queue_vertex(-32'sd1, -32'sd1, -32'sd1, ONE, '0);
        queue_vertex(-32'sd1, -32'sd1, -32'sd1, '0, ONE);
        // All ones, all zeros, then the largest values with the smallest tex_v.
        queue_vertex(-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1);
        queue_vertex('0, '0, '0, '0, '0);
        queue_vertex(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MIN);
        drive_queue();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    idle_pct  <= 0;
                    stall_pct <= 0;
                end
                1: begin
                    idle_pct  <= 71;
                    stall_pct <= 0;
                end
                2: begin
                    idle_pct  <= 0;
                    stall_pct <= 71;
                end
                default: begin
                    idle_pct  <= 14;
                    stall_pct <= 14;
                end
            endcase
            @(posedge i_clk);
            for (int t = 0; t < TRIANGLES_PER_PHASE; t++) begin
                queue_random_triangle();
            end
            drive_queue();
        end

        @(posedge i_clk);
        while (pending != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
